// ===== rtl/dcda_pkg.sv =====
// Shared constants, types and rate table for the decimating averager.
package dcda_pkg;

  localparam int CHANNELS    = 2;
  localparam int SMP_W       = 24;
  localparam int SUM_W       = 32;
  localparam int AVG_W       = 16;
  localparam int RATE_W      = 3;
  localparam int OSR_W       = 2;
  localparam int LEN_W       = 8;
  localparam int LANE_STAGES = 6;

  // |sum * scale| <= 244 * 2^23 < 2^31
  localparam int MAG_W       = 31;
  localparam int Q_W         = 15;
  localparam int DIV_W       = 17;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 31;

  localparam logic [DIV_W-1:0]   DIVISOR = 17'd81223;
  // floor(2^31 / 81223); quotient estimate is low by at most one
  localparam logic [RECIP_W-1:0] RECIP   = 15'd26439;

  localparam logic [RATE_W-1:0] RATE_976SPS = 3'd0;
  localparam logic [RATE_W-1:0] RATE_488SPS = 3'd1;
  localparam logic [RATE_W-1:0] RATE_244SPS = 3'd2;
  localparam logic [RATE_W-1:0] RATE_122SPS = 3'd3;
  localparam logic [RATE_W-1:0] RATE_61SPS  = 3'd4;
  localparam logic [RATE_W-1:0] RATE_4SPS   = 3'd5;
  localparam logic [RATE_W-1:0] RATE_2SPS   = 3'd6;
  localparam logic [RATE_W-1:0] RATE_1SPS   = 3'd7;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_2SPS;

  localparam logic [OSR_W-1:0] OSR_1024 = 2'd0;
  localparam logic [OSR_W-1:0] OSR_2048 = 2'd1;
  localparam logic [OSR_W-1:0] OSR_4096 = 2'd2;

  // Per-stage control broadcast to every lane
  typedef struct packed {
    logic                   acc_en;
    logic                   blk_end;
    logic [LANE_STAGES-1:0] ld;
    logic [LEN_W-1:0]       scale;
  } lane_ctl_t;

  // Side data leaving the last lane stage toward the output register
  typedef struct packed {
    logic              valid;
    logic [RATE_W-1:0] rate;
    logic [OSR_W-1:0]  osr;
  } tail_t;

  function automatic logic [LEN_W-1:0] rate_len(input logic [RATE_W-1:0] rate);
    logic [LEN_W-1:0] len;
    case (rate)
      RATE_122SPS: len = 8'd2;
      RATE_61SPS:  len = 8'd4;
      RATE_4SPS:   len = 8'd61;
      RATE_2SPS:   len = 8'd122;
      RATE_1SPS:   len = 8'd244;
      default:     len = 8'd1;
    endcase
    return len;
  endfunction

  function automatic logic [LEN_W-1:0] rate_scale(input logic [RATE_W-1:0] rate);
    logic [LEN_W-1:0] scl;
    case (rate)
      RATE_122SPS: scl = 8'd122;
      RATE_61SPS:  scl = 8'd61;
      RATE_4SPS:   scl = 8'd4;
      RATE_2SPS:   scl = 8'd2;
      RATE_1SPS:   scl = 8'd1;
      default:     scl = 8'd244;
    endcase
    return scl;
  endfunction

  function automatic logic [OSR_W-1:0] rate_osr(input logic [RATE_W-1:0] rate);
    logic [OSR_W-1:0] osr;
    case (rate)
      RATE_976SPS: osr = OSR_1024;
      RATE_488SPS: osr = OSR_2048;
      default:     osr = OSR_4096;
    endcase
    return osr;
  endfunction

endpackage

// ===== rtl/dcda_ctrl.sv =====
// Block counter, rate state and stage valid/flow control shared by all lanes.
module dcda_ctrl import dcda_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mrg_rdy_i,
  output lane_ctl_t         lane_ctl_o,
  output tail_t             tail_o
);

  localparam int LAST = LANE_STAGES - 1;

  logic [RATE_W-1:0]      req_q, cur_q;
  logic [LEN_W-1:0]       cnt_q, len_q, scl_q;
  logic [LANE_STAGES-1:0] v_q;
  logic [LANE_STAGES-1:0] rdy, ld;
  logic [RATE_W-1:0]      rate_q [LANE_STAGES];
  logic [OSR_W-1:0]       osr_q  [LANE_STAGES];

  logic             accept, blk_end, reload;
  logic [LEN_W:0]   cnt_nxt;
  logic [RATE_W-1:0] new_rate;

  always_comb begin
    rdy[LAST] = !v_q[LAST] || mrg_rdy_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    accept   = in_valid_i && rdy[0];
    cnt_nxt  = {1'b0, cnt_q} + {{LEN_W{1'b0}}, 1'b1};
    blk_end  = cnt_nxt >= {1'b0, len_q};
    reload   = cur_q != req_q;
    new_rate = reload ? req_q : cur_q;
    ld[0]    = accept && blk_end;
    for (int k = 1; k < LANE_STAGES; k++) begin
      ld[k] = rdy[k] && v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= RATE_RESET;
      cur_q <= RATE_RESET;
      len_q <= rate_len(RATE_RESET);
      scl_q <= rate_scale(RATE_RESET);
      cnt_q <= '0;
      v_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        req_q <= cfg_wdata_i;
      end
      if (accept) begin
        cnt_q <= blk_end ? '0 : cnt_nxt[LEN_W-1:0];
        // new rate only at a block boundary, and only when it differs
        if (blk_end && reload) begin
          cur_q <= req_q;
          len_q <= rate_len(req_q);
          scl_q <= rate_scale(req_q);
        end
      end
      if (rdy[0]) begin
        v_q[0] <= accept && blk_end;
      end
      for (int k = 1; k < LANE_STAGES; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      rate_q[0] <= new_rate;
      osr_q[0]  <= rate_osr(new_rate);
    end
    for (int k = 1; k < LANE_STAGES; k++) begin
      if (ld[k]) begin
        rate_q[k] <= rate_q[k-1];
        osr_q[k]  <= osr_q[k-1];
      end
    end
  end

  assign in_stall_o = !rdy[0];

  assign lane_ctl_o.acc_en  = accept;
  assign lane_ctl_o.blk_end = blk_end;
  assign lane_ctl_o.ld      = ld;
  assign lane_ctl_o.scale   = scl_q;

  assign tail_o.valid = v_q[LAST];
  assign tail_o.rate  = rate_q[LAST];
  assign tail_o.osr   = osr_q[LAST];

endmodule

// ===== rtl/dcda_lane.sv =====
// One channel: running sum, then scale and divide by a constant over five stages.
module dcda_lane import dcda_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctl_t               ctl_i,
  input  logic signed [SMP_W-1:0] sample_i,
  output logic signed [AVG_W-1:0] avg_o
);

  logic signed [SUM_W-1:0] sum_q, blk_q, prod_q;
  logic        [LEN_W-1:0] scl_q;
  logic        [MAG_W-1:0] mag3_q, mag4_q, mag5_q, p2_q;
  logic                    neg3_q, neg4_q, neg5_q;
  logic        [Q_W-1:0]   q04_q, q05_q;
  logic signed [AVG_W-1:0] res_q;

  logic signed [SUM_W-1:0]         smp_ext, sum_add, prod_neg;
  logic signed [SUM_W+LEN_W:0]     prod_full;
  logic        [MAG_W+RECIP_W-1:0] est_full;
  logic        [Q_W+DIV_W-1:0]     p2_full;
  logic        [MAG_W-1:0]         rem;
  logic        [AVG_W-1:0]         q_fix;

  always_comb begin
    smp_ext   = SUM_W'(sample_i);
    sum_add   = sum_q + smp_ext;
    prod_full = blk_q * $signed({1'b0, scl_q});
    prod_neg  = -prod_q;
    est_full  = mag3_q * RECIP;
    p2_full   = q04_q * DIVISOR;
    rem       = mag5_q - p2_q;
    // estimate may be one short
    q_fix     = AVG_W'(q05_q) + ((rem >= MAG_W'(DIVISOR)) ? AVG_W'(1) : AVG_W'(0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctl_i.acc_en) begin
      sum_q <= ctl_i.blk_end ? '0 : sum_add;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[0]) begin
      blk_q <= sum_add;
      scl_q <= ctl_i.scale;
    end
    if (ctl_i.ld[1]) begin
      prod_q <= prod_full[SUM_W-1:0];
    end
    if (ctl_i.ld[2]) begin
      neg3_q <= prod_q[SUM_W-1];
      mag3_q <= prod_q[SUM_W-1] ? prod_neg[MAG_W-1:0] : prod_q[MAG_W-1:0];
    end
    if (ctl_i.ld[3]) begin
      q04_q  <= est_full[RECIP_SHIFT +: Q_W];
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
    end
    if (ctl_i.ld[4]) begin
      p2_q   <= p2_full[MAG_W-1:0];
      q05_q  <= q04_q;
      mag5_q <= mag4_q;
      neg5_q <= neg4_q;
    end
    if (ctl_i.ld[5]) begin
      res_q <= neg5_q ? -$signed(q_fix) : $signed(q_fix);
    end
  end

  assign avg_o = res_q;

endmodule

// ===== rtl/dcda_merge.sv =====
// Output register: joins the lane averages with the rate fields into one result.
module dcda_merge import dcda_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tail_t                   tail_i,
  input  logic signed [AVG_W-1:0] lane_avg_i [CHANNELS],
  output logic                    mrg_rdy_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [AVG_W-1:0] avg_o [CHANNELS],
  output logic [RATE_W-1:0]       rate_o,
  output logic [OSR_W-1:0]        osr_o
);

  logic                    out_v_q;
  logic signed [AVG_W-1:0] avg_q [CHANNELS];
  logic [RATE_W-1:0]       rate_q;
  logic [OSR_W-1:0]        osr_q;

  assign mrg_rdy_o = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (mrg_rdy_o) begin
      out_v_q <= tail_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mrg_rdy_o && tail_i.valid) begin
      for (int c = 0; c < CHANNELS; c++) begin
        avg_q[c] <= lane_avg_i[c];
      end
      rate_q <= tail_i.rate;
      osr_q  <= tail_i.osr;
    end
  end

  assign out_valid_o = out_v_q;
  assign avg_o       = avg_q;
  assign rate_o      = rate_q;
  assign osr_o       = osr_q;

endmodule

// ===== rtl/dual_channel_decimating_averager.sv =====
// Top level of the dual-channel boxcar decimating averager.
//
// Input channel: one request per cycle carries a signed 24-bit sample pair
// (in_valid_i / in_stall_o). Each channel is summed over a block of samples;
// the block length and scale come from the rate code in force.
// Output channel: one request per block (out_valid_o / out_stall_i) with
// sum * scale / 81223 truncated toward zero per channel, the rate code in
// force after the boundary and its oversampling code.
// cfg_we_i writes the requested rate; it is taken over at the next block
// boundary if it differs from the current rate.
// Throughput: one sample pair per cycle while in_stall_o is low, set by the
// running-sum adder in each lane. The result of a block passes from the edge
// that accepts its last sample through lane stage 0 (loaded at that edge),
// five more lane stages, then the output register.
// Reset clears the sums and counter, restores rate code 6 (122 samples per
// block, scale 2) and empties the pipeline.
// A stalled result holds in the output register; the lane pipeline keeps
// accepting samples until every stage holds an undelivered result, and only
// then raises in_stall_o.
module dual_channel_decimating_averager import dcda_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [RATE_W-1:0]       cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [SMP_W-1:0] sample_ch0_i,
  input  logic signed [SMP_W-1:0] sample_ch1_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [AVG_W-1:0] average_ch0_o,
  output logic signed [AVG_W-1:0] average_ch1_o,
  output logic [RATE_W-1:0]       rate_in_use_o,
  output logic [OSR_W-1:0]        oversampling_code_o
);

  lane_ctl_t               lane_ctl;
  tail_t                   tail;
  logic                    mrg_rdy;
  logic signed [SMP_W-1:0] samples  [CHANNELS];
  logic signed [AVG_W-1:0] lane_avg [CHANNELS];
  logic signed [AVG_W-1:0] avg      [CHANNELS];

  assign samples[0] = sample_ch0_i;
  assign samples[1] = sample_ch1_i;

  dcda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mrg_rdy_i  (mrg_rdy),
    .lane_ctl_o (lane_ctl),
    .tail_o     (tail)
  );

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    dcda_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (lane_ctl),
      .sample_i(samples[c]),
      .avg_o   (lane_avg[c])
    );
  end

  dcda_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tail_i     (tail),
    .lane_avg_i (lane_avg),
    .mrg_rdy_o  (mrg_rdy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .avg_o      (avg),
    .rate_o     (rate_in_use_o),
    .osr_o      (oversampling_code_o)
  );

  assign average_ch0_o = avg[0];
  assign average_ch1_o = avg[1];

endmodule

// ===== rtl/dcda_checker.sv =====
// Port-level checks for the decimating averager, bound to the top level.
module dcda_checker import dcda_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [AVG_W-1:0] average_ch0_o,
  input logic signed [AVG_W-1:0] average_ch1_o,
  input logic [RATE_W-1:0]       rate_in_use_o,
  input logic [OSR_W-1:0]        oversampling_code_o
);

  // no result may be pending once a clock edge has passed inside reset
  a_no_out_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  a_osr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (rate_in_use_o == RATE_976SPS && oversampling_code_o == OSR_1024) ||
      (rate_in_use_o == RATE_488SPS && oversampling_code_o == OSR_2048) ||
      (rate_in_use_o != RATE_976SPS && rate_in_use_o != RATE_488SPS &&
       oversampling_code_o == OSR_4096))
    else $error("oversampling code does not match rate");

  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      average_ch0_o <= 16'sd25201 && average_ch0_o >= -16'sd25201 &&
      average_ch1_o <= 16'sd25201 && average_ch1_o >= -16'sd25201)
    else $error("average out of range");

endmodule

bind dual_channel_decimating_averager dcda_checker u_checker (.*);
